@@ rtl/free_bitmap_allocator_top_assert.svh @@
// Assertion macros shared by the free bitmap allocator RTL.
`ifndef FREE_BITMAP_ALLOCATOR_TOP_ASSERT_SVH
`define FREE_BITMAP_ALLOCATOR_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication: whenever pre holds, post holds too.
`define ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed: same-cycle implication");
// Next-cycle implication: whenever pre holds, post holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

@@ rtl/fba_pkg.sv @@
// Shared types and constants of the free bitmap allocator.
`timescale 1ns / 1ps
package fba_pkg;
   localparam int INDEX_W = 10;
   localparam int COUNT_W = 11;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

   // Operation codes of a request beat.
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef struct packed {
      logic               operation;
      logic [INDEX_W-1:0] element_index;
   } req_type;

   typedef struct packed {
      logic               ok;
      logic [INDEX_W-1:0] allocated_index;
   } rsp_type;

   // Update of the per-chunk tracking flags after a write-back.
   typedef struct packed {
      logic update;
      logic full;
   } chunk_upd_type;
endpackage

@@ rtl/fba_chunk_ram.sv @@
// Synchronous chunk memory with one write port and one registered read port.
`timescale 1ns / 1ps
module fba_chunk_ram #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 32,
   parameter int AW    = 5
) (
   input  logic             clock,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and read in the same clocked block; read data is registered and shows in the next cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

@@ rtl/fba_chunk_track.sv @@
// Per-chunk written and full flags, and the pick of the first chunk that is not full.
`timescale 1ns / 1ps
module fba_chunk_track #(
   parameter int COUNT = 32,
   parameter int AW    = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  fba_pkg::chunk_upd_type upd,
   input  logic [AW-1:0]         upd_addr,
   input  logic [AW-1:0]         look_addr,
   output logic                  look_valid,
   output logic [AW-1:0]         pick_addr,
   output logic                  pick_none
);
   import fba_pkg::*;

   logic [COUNT-1:0] valid_ff;
   logic [COUNT-1:0] full_ff;

   // A chunk that was never written reads as all free; reset clears every flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         full_ff  <= '0;
      end else if (upd.update) begin
         valid_ff[upd_addr] <= 1'b1;
         full_ff[upd_addr]  <= upd.full;
      end
   end

   assign look_valid = valid_ff[look_addr];

   // Priority pick of the lowest chunk that still has a free bit.
   always_comb begin
      pick_addr = '0;
      pick_none = 1'b1;
      for (int i = COUNT - 1; i >= 0; i--) begin
         if (!full_ff[i]) begin
            pick_addr = AW'(i);
            pick_none = 1'b0;
         end
      end
   end
endmodule

@@ rtl/free_bitmap_allocator_top.sv @@
// Top level of the free bitmap allocator: request control and chunk read-modify-write.
//
// Usage:
//   req_*  : request beats (operation, element_index). Allocate takes the lowest
//            free element below the configured count; free releases element_index.
//   rsp_*  : one response beat per request (ok, allocated_index).
//   csr_*  : write of element_count; always ready. It is to be written only while
//            idle; the user must keep to this, the block does not enforce it.
// An accepted request reads its chunk and moves to ST_RMW, which writes the chunk
//   back on success and loads the response into the output register. Requests
//   are taken one at a time, set by the single chunk memory.
// The chunk for an allocate comes from a flag vector of full chunks, so no scan
//   of the memory is needed.
// Reset: the bitmap reads as all free at once (per-chunk written flags are
//   cleared) and element_count returns to 1024; no clearing pass is needed.
// Stall: a response waiting on rsp_ready holds in its output register; the next
//   request is accepted in the cycle that response is taken, or any later cycle.
`timescale 1ns / 1ps
`include "free_bitmap_allocator_top_assert.svh"
module free_bitmap_allocator_top #(
   parameter int MAX_ELEMENTS = 1024,
   parameter int CHUNK_BITS   = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  fba_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output fba_pkg::rsp_type              rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [fba_pkg::COUNT_W-1:0]   csr_data
);
   import fba_pkg::*;

   localparam int CHUNK_COUNT = (MAX_ELEMENTS + CHUNK_BITS - 1) / CHUNK_BITS;
   localparam int AW = (CHUNK_COUNT > 1) ? $clog2(CHUNK_COUNT) : 1;
   localparam int BW = $clog2(CHUNK_BITS);
   localparam int EW = AW + BW;
   localparam int XW = (EW > INDEX_W) ? EW : INDEX_W;
   localparam int CW = (EW + 1 > COUNT_W) ? EW + 1 : COUNT_W;

   typedef enum logic {
      ST_IDLE,
      ST_RMW
   } state_type;

   state_type        state_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;
   logic [COUNT_W-1:0] cnt_ff;
   logic             op_ff;
   logic [XW-1:0]    idx_ff;
   logic [AW-1:0]    addr_ff;
   logic             none_ff;

   logic                  req_fire;
   logic [XW-1:0]         req_idx_x;
   logic [AW-1:0]         rd_addr;
   logic [CHUNK_BITS-1:0] rd_data;
   logic                  look_valid;
   logic [AW-1:0]         pick_addr;
   logic                  pick_none;
   logic [CHUNK_BITS-1:0] word;
   logic [BW-1:0]         free_bit;
   logic                  free_found;
   logic [EW-1:0]         alloc_e;
   logic [CW-1:0]         eff_count;
   logic [CW-1:0]         cnt_x;
   logic                  alloc_ok;
   logic                  free_ok;
   logic                  op_ok;
   logic [CHUNK_BITS-1:0] set_mask;
   logic [CHUNK_BITS-1:0] clr_mask;
   logic                  ram_wr_en;
   logic [CHUNK_BITS-1:0] ram_wr_data;
   chunk_upd_type         upd;
   rsp_type               rsp_in;

   // One request at a time; the output register must be free or emptying.
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // Chunk to read: the first non-full chunk for allocate, the indexed one for free.
   assign req_idx_x = XW'(req_data.element_index);
   assign rd_addr   = (req_data.operation == OP_ALLOC) ? pick_addr : req_idx_x[BW +: AW];

   fba_chunk_ram #(
      .DEPTH (CHUNK_COUNT),
      .WIDTH (CHUNK_BITS),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .rd_en   (req_fire),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (ram_wr_en),
      .wr_addr (addr_ff),
      .wr_data (ram_wr_data)
   );

   fba_chunk_track #(
      .COUNT (CHUNK_COUNT),
      .AW    (AW)
   ) u_track (
      .clock      (clock),
      .reset      (reset),
      .upd        (upd),
      .upd_addr   (addr_ff),
      .look_addr  (addr_ff),
      .look_valid (look_valid),
      .pick_addr  (pick_addr),
      .pick_none  (pick_none)
   );

   // A chunk never written since reset is all free.
   assign word = look_valid ? rd_data : '0;

   // Lowest clear bit of the chunk that was read.
   always_comb begin
      free_bit   = '0;
      free_found = 1'b0;
      for (int b = CHUNK_BITS - 1; b >= 0; b--) begin
         if (!word[b]) begin
            free_bit   = BW'(b);
            free_found = 1'b1;
         end
      end
   end

   // Limit checks against the count, clamped to the capacity.
   assign cnt_x     = CW'(cnt_ff);
   assign eff_count = (cnt_x > CW'(MAX_ELEMENTS)) ? CW'(MAX_ELEMENTS) : cnt_x;
   assign alloc_e   = {addr_ff, free_bit};
   assign alloc_ok  = !none_ff && free_found && (CW'(alloc_e) < eff_count);
   assign free_ok   = CW'(idx_ff) < eff_count;
   assign op_ok     = (op_ff == OP_ALLOC) ? alloc_ok : free_ok;

   // Modified chunk and its write-back.
   assign set_mask    = CHUNK_BITS'(1) << free_bit;
   assign clr_mask    = CHUNK_BITS'(1) << idx_ff[BW-1:0];
   assign ram_wr_data = (op_ff == OP_ALLOC) ? (word | set_mask) : (word & ~clr_mask);
   assign ram_wr_en   = (state_ff == ST_RMW) && op_ok;
   assign upd.update  = ram_wr_en;
   assign upd.full    = &ram_wr_data;

   assign rsp_in.ok              = op_ok;
   assign rsp_in.allocated_index = ((op_ff == OP_ALLOC) && alloc_ok) ?
                                   INDEX_W'(alloc_e) : '0;

   // Sequencer, request capture, output register and count register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= COUNT_RESET;
      end else begin
         if (csr_valid && csr_ready) begin
            cnt_ff <= csr_data;
         end
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  op_ff    <= req_data.operation;
                  idx_ff   <= req_idx_x;
                  addr_ff  <= rd_addr;
                  none_ff  <= pick_none;
                  state_ff <= ST_RMW;
               end
            end
            ST_RMW: begin
               rsp_valid_ff <= 1'b1;
               rsp_data_ff  <= rsp_in;
               state_ff     <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks on the sequencing of the read-modify-write.
   `ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready)
   `ASSERT_NEXT(a_rsp_follows_rmw, clock, reset, state_ff == ST_RMW, rsp_valid)
   `ASSERT_IMPLY(a_fail_zero_index, clock, reset, rsp_valid && !rsp_data.ok, rsp_data.allocated_index == '0)
   `ASSERT_IMPLY(a_write_in_rmw, clock, reset, ram_wr_en, state_ff == ST_RMW)
endmodule

@@ tb/fba_checker.sv @@
// Checker for the free bitmap allocator: tracks the bitmap, predicts each response and compares.
`timescale 1ns / 1ps
module fba_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  fba_pkg::req_type             req_data,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  fba_pkg::rsp_type             rsp_data,
   input  logic                         csr_valid,
   input  logic                         csr_ready,
   input  logic [fba_pkg::COUNT_W-1:0]  csr_data,
   output int                           fail_count,
   output int                           pending,
   output int                           grants,
   output int                           grant_refusals,
   output int                           releases,
   output int                           release_refusals,
   output int                           peak_index
);
   localparam int CAPACITY = 1024;

   // Shadow copy of the block's state.
   bit [CAPACITY-1:0]            in_use;
   logic [fba_pkg::COUNT_W-1:0]  element_limit;
   fba_pkg::rsp_type             owed_outcomes[$];

   // Prints one line per mismatch and counts it.
   task automatic flag_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      fail_count++;
   endtask

   // Applies one request to the shadow bitmap and returns the response it owes.
   function automatic fba_pkg::rsp_type serve(input fba_pkg::req_type r);
      fba_pkg::rsp_type outcome;
      int unsigned      span;
      bit               found;
      outcome = '0;
      found   = 1'b0;
      span    = (element_limit > CAPACITY) ? CAPACITY : element_limit;
      if (r.operation == fba_pkg::OP_ALLOC) begin
         // The lowest free element below the count is taken.
         for (int e = 0; e < span; e++) begin
            if (!found && !in_use[e]) begin
               found                   = 1'b1;
               in_use[e]               = 1'b1;
               outcome.ok              = 1'b1;
               outcome.allocated_index = e[fba_pkg::INDEX_W-1:0];
            end
         end
      end else if (r.element_index < span) begin
         // Freeing an element that is already free still succeeds.
         in_use[r.element_index] = 1'b0;
         outcome.ok              = 1'b1;
      end
      return outcome;
   endfunction

   // All three channels are sampled at the rising edge.
   always @(posedge clock) begin
      fba_pkg::rsp_type want;
      fba_pkg::rsp_type got;
      if (reset) begin
         in_use        = '0;
         element_limit = fba_pkg::COUNT_RESET;
         owed_outcomes.delete();
      end else begin
         if (csr_valid && csr_ready)
            element_limit = csr_data;

         // Each response beat is matched against the oldest owed outcome.
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            if (owed_outcomes.size() == 0) begin
               flag_mismatch($sformatf("response ok=%0b index=%0d with none owed",
                                       got.ok, got.allocated_index));
            end else begin
               want = owed_outcomes.pop_front();
               if (got.ok !== want.ok)
                  flag_mismatch($sformatf("ok is %0b, predicted %0b", got.ok, want.ok));
               if (got.allocated_index !== want.allocated_index)
                  flag_mismatch($sformatf("allocated_index is %0d, predicted %0d",
                                          got.allocated_index, want.allocated_index));
            end
         end

         // Each accepted request beat is predicted at once.
         if (req_valid && req_ready) begin
            want = serve(req_data);
            owed_outcomes.push_back(want);
            if (req_data.operation == fba_pkg::OP_ALLOC) begin
               if (want.ok) begin
                  grants++;
                  if (int'(want.allocated_index) > peak_index)
                     peak_index = int'(want.allocated_index);
               end else begin
                  grant_refusals++;
               end
            end else if (want.ok) begin
               releases++;
            end else begin
               release_refusals++;
            end
         end
      end
      pending = owed_outcomes.size();
   end

   initial begin
      fail_count       = 0;
      pending          = 0;
      grants           = 0;
      grant_refusals   = 0;
      releases         = 0;
      release_refusals = 0;
      peak_index       = 0;
   end
endmodule

@@ tb/tb_free_bitmap_allocator_top.sv @@
// Testbench top for the free bitmap allocator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_free_bitmap_allocator_top;
   localparam int PERIOD       = 12;
   localparam int LIMIT_CYCLES = 400000;
   localparam int CAPACITY     = 1024;
   localparam int HOLD_CYCLES  = 160;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_ready;
   fba_pkg::req_type             req_data;
   logic                         rsp_valid;
   logic                         rsp_ready;
   fba_pkg::rsp_type             rsp_data;
   logic                         csr_valid;
   logic                         csr_ready;
   logic [fba_pkg::COUNT_W-1:0]  csr_data;

   int fail_count, pending;
   int grants, grant_refusals, releases, release_refusals, peak_index;

   // Stimulus state; idling and hold_asked are also read by the response side.
   bit          idling;
   bit          hold_asked;
   int unsigned managed;
   int          settings_written;

   free_bitmap_allocator_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   fba_checker bitmap_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data),
      .fail_count       (fail_count),
      .pending          (pending),
      .grants           (grants),
      .grant_refusals   (grant_refusals),
      .releases         (releases),
      .release_refusals (release_refusals),
      .peak_index       (peak_index)
   );

   initial begin
      clock = 1'b0;
      forever #(PERIOD / 2) clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #(LIMIT_CYCLES * PERIOD);
      $display("Timeout after %0d cycles.", LIMIT_CYCLES);
      $display("*** FAILED ***");
      $finish;
   end

   // Response side: random stall bursts while idling is set, plus one long hold-off when asked.
   initial begin
      int  stall_left;
      int  hold_left;
      bit  hold_used;
      stall_left = 0;
      hold_left  = 0;
      hold_used  = 1'b0;
      rsp_ready  = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         if (hold_asked && !hold_used) begin
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (idling && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 11) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Presents one request beat and returns at the falling edge after it is taken.
   task automatic offer(input logic op, input logic [fba_pkg::INDEX_W-1:0] index);
      fba_pkg::req_type beat;
      beat.operation     = op;
      beat.element_index = index;
      req_data  <= beat;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Waits until every response is back, so the count can be changed safely.
   task automatic drain;
      wait (pending == 0);
      @(negedge clock);
   endtask

   // Writes element_count over the register channel.
   task automatic set_count(input logic [fba_pkg::COUNT_W-1:0] value);
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      managed = (value > CAPACITY) ? CAPACITY : value;
      settings_written++;
   endtask

   // Half the time near the managed range, otherwise anywhere in the index field.
   function automatic logic [fba_pkg::INDEX_W-1:0] pick_index(input int unsigned span);
      int unsigned top;
      top = (span + 1 > CAPACITY - 1) ? CAPACITY - 1 : span + 1;
      if ($urandom_range(0, 1) == 0)
         return fba_pkg::INDEX_W'($urandom_range(0, CAPACITY - 1));
      return fba_pkg::INDEX_W'($urandom_range(0, top));
   endfunction

   // One phase: a count setting followed by a stream of random requests.
   task automatic run_phase(input logic [fba_pkg::COUNT_W-1:0] count, input int beats,
                            input int alloc_pct, input bit with_idle, input bit long_hold);
      logic op;
      drain();
      set_count(count);
      idling = with_idle;
      if (long_hold)
         hold_asked = 1'b1;
      for (int i = 0; i < beats; i++) begin
         op = ($urandom_range(0, 99) < alloc_pct) ? fba_pkg::OP_ALLOC : fba_pkg::OP_FREE;
         offer(op, pick_index(managed));
         if (with_idle && $urandom_range(0, 3) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clock);
         end
      end
      req_valid <= 1'b0;
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data         = '0;
      csr_valid        = 1'b0;
      csr_data         = '0;
      idling           = 1'b0;
      hold_asked       = 1'b0;
      managed          = CAPACITY;
      settings_written = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: reset count, repeated free of a free element, top index.
      offer(fba_pkg::OP_ALLOC, 10'd0);
      offer(fba_pkg::OP_ALLOC, 10'd0);
      offer(fba_pkg::OP_FREE, 10'd0);
      offer(fba_pkg::OP_FREE, 10'd0);
      offer(fba_pkg::OP_ALLOC, 10'd0);
      offer(fba_pkg::OP_FREE, 10'd1023);
      offer(fba_pkg::OP_ALLOC, 10'd1023);
      req_valid <= 1'b0;

      // Directed: a full bitmap and a free just past the count.
      drain();
      set_count(11'd3);
      offer(fba_pkg::OP_ALLOC, 10'd0);
      offer(fba_pkg::OP_FREE, 10'd3);
      offer(fba_pkg::OP_FREE, 10'd2);
      offer(fba_pkg::OP_ALLOC, 10'd1023);
      req_valid <= 1'b0;

      // Directed: a zero count refuses everything.
      drain();
      set_count(11'd0);
      offer(fba_pkg::OP_ALLOC, 10'd0);
      offer(fba_pkg::OP_FREE, 10'd0);
      req_valid <= 1'b0;

      // Directed: a count above capacity acts as the capacity.
      drain();
      set_count(11'd2047);
      offer(fba_pkg::OP_ALLOC, 10'd0);
      offer(fba_pkg::OP_FREE, 10'd1023);
      offer(fba_pkg::OP_FREE, 10'd3);
      req_valid <= 1'b0;

      // Directed: a single managed element.
      drain();
      set_count(11'd1);
      offer(fba_pkg::OP_FREE, 10'd0);
      offer(fba_pkg::OP_ALLOC, 10'd0);
      offer(fba_pkg::OP_ALLOC, 10'd0);
      req_valid <= 1'b0;

      // Random phases; the bitmap carries over from one to the next.
      run_phase(11'd2047, 580, 85, 1'b1, 1'b0);
      run_phase(11'd1, 40, 50, 1'b1, 1'b0);
      run_phase(11'd0, 20, 50, 1'b0, 1'b0);
      run_phase(11'd32, 80, 60, 1'b1, 1'b0);
      run_phase(11'd33, 80, 60, 1'b0, 1'b0);
      run_phase(fba_pkg::COUNT_W'($urandom_range(1, 64)), 100, 60, 1'b1, 1'b1);
      run_phase(fba_pkg::COUNT_RESET, 250, 95, 1'b1, 1'b0);
      run_phase(fba_pkg::COUNT_W'($urandom_range(0, 2047)), 100, 55, 1'b1, 1'b0);
      run_phase(fba_pkg::COUNT_W'($urandom_range(1, 100)), 100, 60, 1'b1, 1'b0);
      run_phase(fba_pkg::COUNT_W'($urandom_range(1, 48)), 120, 60, 1'b0, 1'b0);

      wait (pending == 0);
      repeat (8) @(posedge clock);
      $display("Covered %0d allocations granted (highest index %0d) and %0d refused;",
               grants, peak_index, grant_refusals);
      $display("%0d frees accepted, %0d rejected, over %0d count settings and a long stall.",
               releases, release_refusals, settings_written);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule
